FILE: rtl/core/asid_pkg.sv
// Shared types and constants for the shock and impulse detector.
package asid_pkg;

  // Sample and datapath widths
  localparam int SAMPLE_BITS = 16;
  localparam int DIFF_W      = SAMPLE_BITS + 1;
  localparam int ENERGY_W    = 36;
  localparam int SUM_W       = 18;
  localparam int WLEN_W      = 10;
  localparam int PERIOD_W    = 20;
  localparam int DIVISOR_W   = PERIOD_W + 1;
  localparam int DIV_STEPS   = ENERGY_W;
  localparam int DIV_CNT_W   = 6;
  localparam int RATE_STEPS  = 5;
  localparam int PADDR_W     = 5;
  localparam int PDATA_W     = 64;

  // Register indexes (byte address is 8 * index)
  localparam logic [1:0] REG_SHOCK_THRESHOLD = 2'd0;
  localparam logic [1:0] REG_WINDOW_LENGTH   = 2'd1;
  localparam logic [1:0] REG_REPORT_PERIOD   = 2'd2;
  localparam logic [1:0] REG_RATING_SCALE    = 2'd3;

  // Register reset values
  localparam logic [ENERGY_W-1:0] RST_SHOCK_THRESHOLD = 36'd43600000;
  localparam logic [WLEN_W-1:0]   RST_WINDOW_LENGTH   = 10'd400;
  localparam logic [PERIOD_W-1:0] RST_REPORT_PERIOD   = 20'd50000;
  localparam logic [ENERGY_W-1:0] RST_RATING_SCALE    = 36'd43600;

  // Impact report codes
  localparam logic       AXIS_X   = 1'b0;
  localparam logic       AXIS_Y   = 1'b1;
  localparam logic [1:0] DIR_NONE = 2'd0;
  localparam logic [1:0] DIR_POS  = 2'd1;
  localparam logic [1:0] DIR_NEG  = 2'd2;

  // Best rating, given when the mean is zero
  localparam logic [2:0] RATING_MAX = 3'd5;

  // Configuration seen by the back end
  typedef struct packed {
    logic [ENERGY_W-1:0] shock_threshold;
    logic [WLEN_W-1:0]   window_length;
    logic [PERIOD_W-1:0] report_period;
    logic [ENERGY_W-1:0] rating_scale;
  } cfg_t;

  // One queued word: per-axis differences against the previous sample
  typedef struct packed {
    logic signed [DIFF_W-1:0] dx;
    logic signed [DIFF_W-1:0] dy;
    logic signed [DIFF_W-1:0] dz;
  } diff_word_t;

  // Back end sequencer states
  typedef enum logic [6:0] {
    ST_IDLE   = 7'b0000001,
    ST_SQ     = 7'b0000010,
    ST_DIV_GO = 7'b0000100,
    ST_DIV    = 7'b0001000,
    ST_UPD    = 7'b0010000,
    ST_RATE   = 7'b0100000,
    ST_OUT    = 7'b1000000
  } back_state_t;

endpackage

FILE: rtl/core/accel_shock_impulse_detector_unit.sv
// Top level of the accelerometer shock and impulse detector with its register port.
//
// Each accepted sample word gives exactly one result word. The front end takes a
// sample whenever the difference queue has room and forms the per-axis deltas; the
// back end works one word at a time and takes no new word until the last one is
// loaded into the output, which the result side can hold off. Each word is fetched,
// squared on the shared squarer, divided by the 36-step bit-serial divider of the
// running mean, used to update the state, rated in the rating steps on a word that
// ends a rating period, and loaded into the output.
// Registers sit at byte address 8 * index on a 64-bit port: shock_threshold (0),
// window_length (1), report_period (2), rating_scale (3). Write them only while
// the block is idle.
module accel_shock_impulse_detector_unit #(
  parameter int QUEUE_DEPTH = 2
) (
  input  logic                                clk,
  input  logic                                rst,
  // Sample channel
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic signed [15:0]                  accel_x,
  input  logic signed [15:0]                  accel_y,
  input  logic signed [15:0]                  accel_z,
  // Result channel
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic [asid_pkg::ENERGY_W-1:0]       jerk_energy,
  output logic [asid_pkg::ENERGY_W-1:0]       mean_energy,
  output logic                                impact_triggered,
  output logic                                impact_valid,
  output logic                                impact_axis,
  output logic [1:0]                          impact_direction,
  output logic                                rating_valid,
  output logic [2:0]                          rating,
  // Register port
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [asid_pkg::PADDR_W-1:0]        paddr,
  input  logic [asid_pkg::PDATA_W-1:0]        pwdata,
  output logic [asid_pkg::PDATA_W-1:0]        prdata,
  output logic                                pready
);

  asid_pkg::cfg_t       cfg;
  logic                 cfg_we;
  logic [1:0]           reg_idx;

  logic                 q_full;
  logic                 q_push;
  asid_pkg::diff_word_t q_push_word;
  logic                 q_pop;
  logic                 q_not_empty;
  asid_pkg::diff_word_t q_head_word;

  assign pready  = 1'b1;
  assign cfg_we  = psel && penable && pwrite && pready;
  assign reg_idx = paddr[asid_pkg::PADDR_W-1:3];

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.shock_threshold <= asid_pkg::RST_SHOCK_THRESHOLD;
      cfg.window_length   <= asid_pkg::RST_WINDOW_LENGTH;
      cfg.report_period   <= asid_pkg::RST_REPORT_PERIOD;
      cfg.rating_scale    <= asid_pkg::RST_RATING_SCALE;
    end else if (cfg_we) begin
      case (reg_idx)
        asid_pkg::REG_SHOCK_THRESHOLD:
          cfg.shock_threshold <= pwdata[asid_pkg::ENERGY_W-1:0];
        asid_pkg::REG_WINDOW_LENGTH:
          cfg.window_length   <= pwdata[asid_pkg::WLEN_W-1:0];
        asid_pkg::REG_REPORT_PERIOD:
          cfg.report_period   <= pwdata[asid_pkg::PERIOD_W-1:0];
        asid_pkg::REG_RATING_SCALE:
          cfg.rating_scale    <= pwdata[asid_pkg::ENERGY_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // Register readback
  always_comb begin
    case (reg_idx)
      asid_pkg::REG_SHOCK_THRESHOLD: prdata = asid_pkg::PDATA_W'(cfg.shock_threshold);
      asid_pkg::REG_WINDOW_LENGTH:   prdata = asid_pkg::PDATA_W'(cfg.window_length);
      asid_pkg::REG_REPORT_PERIOD:   prdata = asid_pkg::PDATA_W'(cfg.report_period);
      asid_pkg::REG_RATING_SCALE:    prdata = asid_pkg::PDATA_W'(cfg.rating_scale);
      default:                       prdata = '0;
    endcase
  end

  asid_front u_front (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .accel_x   (accel_x),
    .accel_y   (accel_y),
    .accel_z   (accel_z),
    .q_full    (q_full),
    .push      (q_push),
    .push_word (q_push_word)
  );

  asid_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (q_push),
    .push_word (q_push_word),
    .full      (q_full),
    .pop       (q_pop),
    .not_empty (q_not_empty),
    .head_word (q_head_word)
  );

  asid_back u_back (
    .clk              (clk),
    .rst              (rst),
    .cfg              (cfg),
    .q_not_empty      (q_not_empty),
    .q_word           (q_head_word),
    .pop              (q_pop),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .jerk_energy      (jerk_energy),
    .mean_energy      (mean_energy),
    .impact_triggered (impact_triggered),
    .impact_valid     (impact_valid),
    .impact_axis      (impact_axis),
    .impact_direction (impact_direction),
    .rating_valid     (rating_valid),
    .rating           (rating)
  );

endmodule

FILE: rtl/core/asid_front.sv
// Front end: accepts samples and forms axis differences against the previous sample.
module asid_front (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     in_valid,
  output logic                     in_ready,
  input  logic signed [15:0]       accel_x,
  input  logic signed [15:0]       accel_y,
  input  logic signed [15:0]       accel_z,
  input  logic                     q_full,
  output logic                     push,
  output asid_pkg::diff_word_t     push_word
);

  logic signed [asid_pkg::SAMPLE_BITS-1:0] prev_x;
  logic signed [asid_pkg::SAMPLE_BITS-1:0] prev_y;
  logic signed [asid_pkg::SAMPLE_BITS-1:0] prev_z;
  logic                                    have_previous;

  logic signed [asid_pkg::SAMPLE_BITS-1:0] sx;
  logic signed [asid_pkg::SAMPLE_BITS-1:0] sy;
  logic signed [asid_pkg::SAMPLE_BITS-1:0] sz;

  assign in_ready = !q_full;
  assign push     = in_valid && in_ready;

  // Low sample bits, sign carried by the top one
  assign sx = accel_x[asid_pkg::SAMPLE_BITS-1:0];
  assign sy = accel_y[asid_pkg::SAMPLE_BITS-1:0];
  assign sz = accel_z[asid_pkg::SAMPLE_BITS-1:0];

  // Differences; the first sample after reset counts as no motion
  always_comb begin
    if (have_previous) begin
      push_word.dx = asid_pkg::DIFF_W'(sx) - asid_pkg::DIFF_W'(prev_x);
      push_word.dy = asid_pkg::DIFF_W'(sy) - asid_pkg::DIFF_W'(prev_y);
      push_word.dz = asid_pkg::DIFF_W'(sz) - asid_pkg::DIFF_W'(prev_z);
    end else begin
      push_word.dx = '0;
      push_word.dy = '0;
      push_word.dz = '0;
    end
  end

  // Previous sample
  always_ff @(posedge clk) begin
    if (rst) begin
      prev_x        <= '0;
      prev_y        <= '0;
      prev_z        <= '0;
      have_previous <= 1'b0;
    end else if (push) begin
      prev_x        <= sx;
      prev_y        <= sy;
      prev_z        <= sz;
      have_previous <= 1'b1;
    end
  end

endmodule

FILE: rtl/core/asid_queue.sv
// Short FIFO of difference words between the front and back ends.
module asid_queue #(
  parameter int DEPTH = 2
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 push,
  input  asid_pkg::diff_word_t push_word,
  output logic                 full,
  input  logic                 pop,
  output logic                 not_empty,
  output asid_pkg::diff_word_t head_word
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  asid_pkg::diff_word_t mem [DEPTH];
  logic [PTR_W-1:0]     wr_ptr;
  logic [PTR_W-1:0]     rd_ptr;
  logic [CNT_W-1:0]     count;

  assign full      = (count == CNT_W'(DEPTH));
  assign not_empty = (count != '0);
  assign head_word = mem[rd_ptr];

  // Storage
  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_word;
    end
  end

  // Pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

FILE: rtl/core/asid_div.sv
// Restoring divider, one quotient bit per cycle, for the running mean update.
module asid_div (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             start,
  input  logic [asid_pkg::ENERGY_W-1:0]    dividend,
  input  logic [asid_pkg::DIVISOR_W-1:0]   divisor,
  output logic                             done,
  output logic [asid_pkg::ENERGY_W-1:0]    quotient
);

  logic [asid_pkg::DIVISOR_W-1:0] dsr;
  logic [asid_pkg::DIVISOR_W-1:0] rem;
  logic [asid_pkg::ENERGY_W-1:0]  dvd;
  logic [asid_pkg::DIV_CNT_W-1:0] cnt;
  logic                           busy;

  logic [asid_pkg::DIVISOR_W:0]   rem_sh;
  logic                           q_bit;

  assign quotient = dvd;

  // Shift in the next dividend bit and try to subtract
  always_comb begin
    rem_sh = {rem, dvd[asid_pkg::ENERGY_W-1]};
    q_bit  = (rem_sh >= {1'b0, dsr});
  end

  always_ff @(posedge clk) begin
    if (start) begin
      dsr <= divisor;
      rem <= '0;
      dvd <= dividend;
    end else if (busy) begin
      rem <= q_bit ? asid_pkg::DIVISOR_W'(rem_sh - {1'b0, dsr})
                   : asid_pkg::DIVISOR_W'(rem_sh);
      dvd <= {dvd[asid_pkg::ENERGY_W-2:0], q_bit};
    end
  end

  // Step counter; done pulses for one cycle after the last step
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= !start && busy && (cnt == asid_pkg::DIV_CNT_W'(1));
      if (start) begin
        busy <= 1'b1;
        cnt  <= asid_pkg::DIV_CNT_W'(asid_pkg::DIV_STEPS);
      end else if (busy) begin
        cnt <= cnt - 1'b1;
        if (cnt == asid_pkg::DIV_CNT_W'(1)) begin
          busy <= 1'b0;
        end
      end
    end
  end

endmodule

FILE: rtl/core/asid_back.sv
// Back end: energy, running mean, impact window and period rating for each word.
module asid_back (
  input  logic                              clk,
  input  logic                              rst,
  input  asid_pkg::cfg_t                    cfg,
  input  logic                              q_not_empty,
  input  asid_pkg::diff_word_t              q_word,
  output logic                              pop,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic [asid_pkg::ENERGY_W-1:0]     jerk_energy,
  output logic [asid_pkg::ENERGY_W-1:0]     mean_energy,
  output logic                              impact_triggered,
  output logic                              impact_valid,
  output logic                              impact_axis,
  output logic [1:0]                        impact_direction,
  output logic                              rating_valid,
  output logic [2:0]                        rating
);

  localparam int EW  = asid_pkg::ENERGY_W;
  localparam int DW  = asid_pkg::DIFF_W;
  localparam int SW  = asid_pkg::SUM_W;
  localparam int PW  = asid_pkg::PERIOD_W;
  localparam int WW  = asid_pkg::WLEN_W;
  localparam int MW  = 2 * DW;
  localparam int RAW = EW + 3;

  localparam logic signed [SW:0] SUM_MAX = (SW+1)'((1 << (SW - 1)) - 1);
  localparam logic signed [SW:0] SUM_MIN = (SW+1)'(-(1 << (SW - 1)));

  asid_pkg::back_state_t state;

  // Current word
  asid_pkg::diff_word_t word;
  logic [1:0]           sq_idx;
  logic [MW-1:0]        prod;
  logic [EW-1:0]        energy;

  // Persistent state
  logic [EW-1:0]        mean_store;
  logic [PW-1:0]        period_count;
  logic                 window_open;
  logic [WW-1:0]        window_count;
  logic signed [SW-1:0] sum_x;
  logic signed [SW-1:0] sum_y;

  // Per-word results
  logic [EW-1:0]        res_mean;
  logic                 res_trig;
  logic                 res_ivalid;
  logic                 res_axis;
  logic [1:0]           res_dir;
  logic                 res_rvalid;
  logic [2:0]           rate_above;
  logic [2:0]           rate_idx;
  logic [RAW-1:0]       rate_acc;

  // Divider
  logic                 div_start;
  logic                 div_done;
  logic [EW-1:0]        div_q;
  logic                 delta_neg;
  logic [EW-1:0]        delta_mag;

  // Update-cycle logic
  logic signed [DW-1:0] sq_d;
  logic [DW-1:0]        sq_mag;
  logic [EW-1:0]        mean_new;
  logic [WW:0]          cnt_inc;
  logic                 win_close;
  logic signed [SW:0]   sx_add;
  logic signed [SW:0]   sy_add;
  logic signed [SW-1:0] sx_sat;
  logic signed [SW-1:0] sy_sat;
  logic [SW-1:0]        ax;
  logic [SW-1:0]        ay;
  logic                 axis_c;
  logic [1:0]           dir_c;
  logic                 trig_c;
  logic [PW-1:0]        pc_inc;
  logic                 period_end;

  assign pop = (state == asid_pkg::ST_IDLE) && q_not_empty;

  // Magnitude of the difference being squared
  always_comb begin
    case (sq_idx)
      2'd0:    sq_d = word.dx;
      2'd1:    sq_d = word.dy;
      default: sq_d = word.dz;
    endcase
    sq_mag = sq_d[DW-1] ? DW'(-sq_d) : DW'(sq_d);
  end

  // Mean delta sign and magnitude
  always_comb begin
    delta_neg = (energy < mean_store);
    delta_mag = delta_neg ? (mean_store - energy) : (energy - mean_store);
    mean_new  = delta_neg ? (mean_store - div_q) : (mean_store + div_q);
  end

  assign div_start = (state == asid_pkg::ST_DIV_GO);

  asid_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (delta_mag),
    .divisor  ({1'b0, period_count} + asid_pkg::DIVISOR_W'(1)),
    .done     (div_done),
    .quotient (div_q)
  );

  // Impact window: report on close, else accumulate, then the trigger test
  always_comb begin
    cnt_inc   = {1'b0, window_count} + (WW+1)'(1);
    win_close = window_open && (cnt_inc >= {1'b0, cfg.window_length});

    sx_add = {sum_x[SW-1], sum_x} + (SW+1)'(word.dx);
    sy_add = {sum_y[SW-1], sum_y} + (SW+1)'(word.dy);
    if (sx_add > SUM_MAX)      sx_sat = SW'(SUM_MAX);
    else if (sx_add < SUM_MIN) sx_sat = SW'(SUM_MIN);
    else                       sx_sat = SW'(sx_add);
    if (sy_add > SUM_MAX)      sy_sat = SW'(SUM_MAX);
    else if (sy_add < SUM_MIN) sy_sat = SW'(SUM_MIN);
    else                       sy_sat = SW'(sy_add);

    ax = sum_x[SW-1] ? SW'(-sum_x) : SW'(sum_x);
    ay = sum_y[SW-1] ? SW'(-sum_y) : SW'(sum_y);
    // y wins only when strictly larger; ties and all-zero go to x
    if (ay > ax) begin
      axis_c = asid_pkg::AXIS_Y;
      dir_c  = (sum_y > 0) ? asid_pkg::DIR_POS : asid_pkg::DIR_NEG;
    end else if (ax != '0) begin
      axis_c = asid_pkg::AXIS_X;
      dir_c  = (sum_x > 0) ? asid_pkg::DIR_POS : asid_pkg::DIR_NEG;
    end else begin
      axis_c = asid_pkg::AXIS_X;
      dir_c  = asid_pkg::DIR_NONE;
    end

    trig_c = !(window_open && !win_close) && (energy >= cfg.shock_threshold);

    pc_inc     = period_count + 1'b1;
    period_end = (pc_inc >= cfg.report_period);
  end

  // Sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= asid_pkg::ST_IDLE;
      mean_store   <= '0;
      period_count <= '0;
      window_open  <= 1'b0;
      window_count <= '0;
      sum_x        <= '0;
      sum_y        <= '0;
      out_valid    <= 1'b0;
    end else begin
      // Output word taken; ST_OUT refills it itself
      if (out_ready && (state != asid_pkg::ST_OUT)) begin
        out_valid <= 1'b0;
      end
      case (state)
        asid_pkg::ST_IDLE: begin
          if (q_not_empty) begin
            word   <= q_word;
            sq_idx <= 2'd0;
            energy <= '0;
            state  <= asid_pkg::ST_SQ;
          end
        end
        // One shared squarer, product registered before the sum
        asid_pkg::ST_SQ: begin
          prod   <= MW'(sq_mag * sq_mag);
          sq_idx <= sq_idx + 1'b1;
          if (sq_idx != 2'd0) begin
            energy <= energy + EW'(prod);
          end
          if (sq_idx == 2'd3) begin
            state <= asid_pkg::ST_DIV_GO;
          end
        end
        asid_pkg::ST_DIV_GO: begin
          state <= asid_pkg::ST_DIV;
        end
        asid_pkg::ST_DIV: begin
          if (div_done) begin
            state <= asid_pkg::ST_UPD;
          end
        end
        asid_pkg::ST_UPD: begin
          res_mean   <= mean_new;
          res_trig   <= trig_c;
          res_ivalid <= win_close;
          res_axis   <= win_close ? axis_c : asid_pkg::AXIS_X;
          res_dir    <= win_close ? dir_c : asid_pkg::DIR_NONE;
          res_rvalid <= period_end;

          if (trig_c) begin
            window_open  <= 1'b1;
            window_count <= '0;
            sum_x        <= '0;
            sum_y        <= '0;
          end else if (win_close) begin
            window_open  <= 1'b0;
            window_count <= '0;
            sum_x        <= '0;
            sum_y        <= '0;
          end else if (window_open) begin
            window_count <= WW'(cnt_inc);
            sum_x        <= sx_sat;
            sum_y        <= sy_sat;
          end

          rate_above <= '0;
          rate_idx   <= '0;
          rate_acc   <= RAW'(cfg.rating_scale);
          if (period_end) begin
            period_count <= '0;
            mean_store   <= '0;
            state        <= asid_pkg::ST_RATE;
          end else begin
            period_count <= pc_inc;
            mean_store   <= mean_new;
            state        <= asid_pkg::ST_OUT;
          end
        end
        // Count how many of scale, 2*scale .. 5*scale the mean exceeds
        asid_pkg::ST_RATE: begin
          if (RAW'(res_mean) > rate_acc) begin
            rate_above <= rate_above + 1'b1;
          end
          rate_acc <= rate_acc + RAW'(cfg.rating_scale);
          rate_idx <= rate_idx + 1'b1;
          if (rate_idx == 3'(asid_pkg::RATE_STEPS - 1)) begin
            state <= asid_pkg::ST_OUT;
          end
        end
        asid_pkg::ST_OUT: begin
          if (!out_valid || out_ready) begin
            out_valid        <= 1'b1;
            jerk_energy      <= energy;
            mean_energy      <= res_mean;
            impact_triggered <= res_trig;
            impact_valid     <= res_ivalid;
            impact_axis      <= res_axis;
            impact_direction <= res_dir;
            rating_valid     <= res_rvalid;
            rating           <= res_rvalid ? (asid_pkg::RATING_MAX - rate_above) : 3'd0;
            state            <= asid_pkg::ST_IDLE;
          end
        end
        default: begin
          state <= asid_pkg::ST_IDLE;
        end
      endcase
    end
  end

endmodule

FILE: tb/tb.sv
// Self-checking testbench for the accelerometer shock and impulse detector.
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int     CLK_HALF    = 5;
  localparam int     RST_CYCLES  = 9;
  localparam int     NUM_PHASES  = 5;
  localparam int     PHASE_ITEMS = 90;
  localparam int     HOLD_CYCLES = 500;
  localparam int     TAIL_CYCLES = 60;
  localparam longint LIMIT_NS    = 3_000_000;
  localparam longint RATING_TOP  = 6;
  localparam longint SUM_HI      = (longint'(1) << (asid_pkg::SUM_W - 1)) - 1;
  localparam longint SUM_LO      = -(longint'(1) << (asid_pkg::SUM_W - 1));
  localparam logic [asid_pkg::ENERGY_W-1:0] ENERGY_MAX = '1;
  localparam logic [asid_pkg::ENERGY_W-1:0] FULL_JUMP  = 36'd12884508675;  // 3 * 65535^2

  // Idle mix per random phase; the last one also holds the output off
  localparam int SEND_IDLE [NUM_PHASES] = '{0, 55, 0, 34, 0};
  localparam int RECV_STALL[NUM_PHASES] = '{0, 0, 55, 34, 0};

  // One result word as seen on the output side
  typedef struct packed {
    logic [asid_pkg::ENERGY_W-1:0] jerk_energy;
    logic [asid_pkg::ENERGY_W-1:0] mean_energy;
    logic                          impact_triggered;
    logic                          impact_valid;
    logic                          impact_axis;
    logic [1:0]                    impact_direction;
    logic                          rating_valid;
    logic [2:0]                    rating;
  } det_word_t;

  typedef enum logic {ROW_SAMPLE, ROW_WRITE} row_kind_t;

  typedef struct {
    row_kind_t                     kind;
    logic [1:0]                    reg_idx;
    logic [asid_pkg::PDATA_W-1:0]  value;
    logic signed [15:0]            x, y, z;
    bit                            energy_known;
    logic [asid_pkg::ENERGY_W-1:0] energy;
  } stim_row_t;

  logic                          clk = 1'b0;
  logic                          rst;
  logic                          in_valid, in_ready;
  logic signed [15:0]            accel_x, accel_y, accel_z;
  logic                          out_valid, out_ready;
  logic [asid_pkg::ENERGY_W-1:0] jerk_energy, mean_energy;
  logic                          impact_triggered, impact_valid, impact_axis;
  logic [1:0]                    impact_direction;
  logic                          rating_valid;
  logic [2:0]                    rating;
  logic                          psel, penable, pwrite;
  logic [asid_pkg::PADDR_W-1:0]  paddr;
  logic [asid_pkg::PDATA_W-1:0]  pwdata, prdata;
  logic                          pready;

  // Detector state mirrored by the testbench
  asid_pkg::cfg_t                cur_cfg;
  logic signed [15:0]            last_smp[3];
  bit                            have_last;
  logic [asid_pkg::ENERGY_W-1:0] run_mean;
  logic [asid_pkg::PERIOD_W-1:0] period_cnt;
  bit                            win_open;
  logic [asid_pkg::WLEN_W-1:0]   win_cnt;
  longint                        sum_x, sum_y;

  det_word_t pending_words[$];
  det_word_t head_word;
  int errors = 0, n_checked = 0, n_trig = 0, n_impact = 0, n_rating = 0, n_sent = 0;
  int send_idle_pct = 0, stall_pct = 0, hold_left = 0;
  bit hold_req = 1'b0, hold_taken = 1'b0;

  accel_shock_impulse_detector_unit u_dut (.*);

  always #CLK_HALF clk = ~clk;

  function automatic longint clip_sum(longint v);
    if (v > SUM_HI) return SUM_HI;
    if (v < SUM_LO) return SUM_LO;
    return v;
  endfunction

  // Expected result word for one sample; advances the mirrored state
  function automatic det_word_t detect_step(logic signed [15:0] ax, ay, az);
    det_word_t w;
    longint    smp[3];
    longint    d[3];
    longint    e, delta, q, mag_x, mag_y, c;
    int        cnt, i;
    w = '0;  // axis x, no direction, no rating unless set below
    smp[0] = ax;
    smp[1] = ay;
    smp[2] = az;
    e = 0;
    for (i = 0; i < 3; i++) begin
      d[i] = have_last ? smp[i] - longint'(last_smp[i]) : 0;
      e += d[i] * d[i];
      last_smp[i] = smp[i][15:0];
    end
    have_last = 1'b1;
    if (e > longint'(ENERGY_MAX)) e = longint'(ENERGY_MAX);
    w.jerk_energy = e[asid_pkg::ENERGY_W-1:0];

    // running mean, quotient truncated toward zero
    delta = e - longint'(run_mean);
    q = delta / (longint'(period_cnt) + 1);
    run_mean = asid_pkg::ENERGY_W'(longint'(run_mean) + q);
    w.mean_energy = run_mean;

    // open window first: accumulate or report
    if (win_open) begin
      cnt = int'(win_cnt) + 1;
      if (cnt >= int'(cur_cfg.window_length)) begin
        mag_x = sum_x < 0 ? -sum_x : sum_x;
        mag_y = sum_y < 0 ? -sum_y : sum_y;
        w.impact_valid = 1'b1;
        if (mag_y > mag_x) begin
          w.impact_axis = asid_pkg::AXIS_Y;
          w.impact_direction = sum_y > 0 ? asid_pkg::DIR_POS : asid_pkg::DIR_NEG;
        end else if (mag_x != 0) begin
          w.impact_axis = asid_pkg::AXIS_X;
          w.impact_direction = sum_x > 0 ? asid_pkg::DIR_POS : asid_pkg::DIR_NEG;
        end
        win_open = 1'b0;
        win_cnt = '0;
        sum_x = 0;
        sum_y = 0;
      end else begin
        sum_x = clip_sum(sum_x + d[0]);
        sum_y = clip_sum(sum_y + d[1]);
        win_cnt = cnt[asid_pkg::WLEN_W-1:0];
      end
    end

    // then the trigger test, which may reopen on the closing sample
    if (!win_open && e >= longint'(cur_cfg.shock_threshold)) begin
      win_open = 1'b1;
      win_cnt = '0;
      sum_x = 0;
      sum_y = 0;
      w.impact_triggered = 1'b1;
    end

    // period end and rating
    period_cnt = period_cnt + 1'b1;
    if (period_cnt >= cur_cfg.report_period) begin
      w.rating_valid = 1'b1;
      if (cur_cfg.rating_scale == '0) begin
        w.rating = run_mean == '0 ? asid_pkg::RATING_MAX : 3'd0;
      end else begin
        c = (longint'(run_mean) + longint'(cur_cfg.rating_scale) - 1) /
            longint'(cur_cfg.rating_scale);
        w.rating = c >= RATING_TOP ? 3'd0 :
                   (c == 0 ? asid_pkg::RATING_MAX : 3'(RATING_TOP - c));
      end
      period_cnt = '0;
      run_mean = '0;
    end
    return w;
  endfunction

  function automatic stim_row_t sample_row(logic signed [15:0] x, y, z, bit known = 1'b0,
                                           logic [asid_pkg::ENERGY_W-1:0] e = '0);
    stim_row_t r;
    r.kind = ROW_SAMPLE;
    r.reg_idx = '0;
    r.value = '0;
    r.x = x;
    r.y = y;
    r.z = z;
    r.energy_known = known;
    r.energy = e;
    return r;
  endfunction

  function automatic stim_row_t write_row(logic [1:0] idx, logic [asid_pkg::PDATA_W-1:0] val);
    stim_row_t r;
    r = sample_row(16'sd0, 16'sd0, 16'sd0);
    r.kind = ROW_WRITE;
    r.reg_idx = idx;
    r.value = val;
    return r;
  endfunction

  function automatic logic signed [15:0] walk_axis(logic signed [15:0] cur, int span);
    int v;
    v = int'(cur) + int'($urandom_range(2 * span)) - span;
    if (v > 32767) v = 32767;
    if (v < -32768) v = -32768;
    return 16'(v);
  endfunction

  function automatic logic signed [15:0] rail_value();
    case ($urandom_range(3))
      0: return -16'sd32768;
      1: return 16'sd32767;
      2: return 16'sd0;
      default: return -16'sd1;
    endcase
  endfunction

  // Mostly a random walk, with full-range jumps, rails and held samples mixed in
  function automatic void random_sample(output logic signed [15:0] x, y, z);
    int m, span;
    m = $urandom_range(99);
    span = m < 35 ? 300 : 6000;
    if (m < 60) begin
      x = walk_axis(last_smp[0], span);
      y = walk_axis(last_smp[1], span);
      z = walk_axis(last_smp[2], span);
    end else if (m < 80) begin
      x = 16'($urandom);
      y = 16'($urandom);
      z = 16'($urandom);
    end else if (m < 90) begin
      x = rail_value();
      y = rail_value();
      z = rail_value();
    end else begin
      x = last_smp[0];
      y = last_smp[1];
      z = last_smp[2];
    end
  endfunction

  // Register write: setup cycle, access cycle, then an idle gap with psel low
  task automatic reg_write(logic [1:0] idx, logic [asid_pkg::PDATA_W-1:0] val);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= asid_pkg::PADDR_W'({idx, 3'b000});
    pwdata <= val;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    case (idx)
      asid_pkg::REG_SHOCK_THRESHOLD:
        cur_cfg.shock_threshold = val[asid_pkg::ENERGY_W-1:0];
      asid_pkg::REG_WINDOW_LENGTH:
        cur_cfg.window_length   = val[asid_pkg::WLEN_W-1:0];
      asid_pkg::REG_REPORT_PERIOD:
        cur_cfg.report_period   = val[asid_pkg::PERIOD_W-1:0];
      asid_pkg::REG_RATING_SCALE:
        cur_cfg.rating_scale    = val[asid_pkg::ENERGY_W-1:0];
      default: ;
    endcase
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    @(negedge clk);
  endtask

  // Offer one sample word; entered and left at a falling edge
  task automatic send_sample(logic signed [15:0] x, y, z, bit known,
                             logic [asid_pkg::ENERGY_W-1:0] e);
    det_word_t w;
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    accel_x <= x;
    accel_y <= y;
    accel_z <= z;
    do @(posedge clk); while (!in_ready);
    w = detect_step(x, y, z);
    if (known) w.jerk_energy = e;
    pending_words.push_back(w);
    n_sent++;
    @(negedge clk);
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    while (pending_words.size() != 0) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic check_field(string name, logic [asid_pkg::ENERGY_W-1:0] expv,
                             logic [asid_pkg::ENERGY_W-1:0] act);
    if (expv !== act) begin
      $error("%s: expected %0d, got %0d", name, expv, act);
      errors++;
    end
  endtask

  // Output side: random stalls, plus one long hold when requested
  initial begin
    out_ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req && !hold_taken) begin
        hold_taken = 1'b1;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        out_ready <= 1'b0;
        hold_left--;
      end else begin
        out_ready <= ($urandom_range(99) >= stall_pct);
      end
    end
  end

  // Compare each accepted result word with the oldest expectation
  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) begin
      if (pending_words.size() == 0) begin
        $error("result word with no expectation pending");
        errors++;
      end else begin
        head_word = pending_words.pop_front();
        check_field("jerk_energy", head_word.jerk_energy, jerk_energy);
        check_field("mean_energy", head_word.mean_energy, mean_energy);
        check_field("impact_triggered", head_word.impact_triggered, impact_triggered);
        check_field("impact_valid", head_word.impact_valid, impact_valid);
        check_field("impact_axis", head_word.impact_axis, impact_axis);
        check_field("impact_direction", head_word.impact_direction, impact_direction);
        check_field("rating_valid", head_word.rating_valid, rating_valid);
        check_field("rating", head_word.rating, rating);
        n_checked++;
        n_trig += head_word.impact_triggered;
        n_impact += head_word.impact_valid;
        n_rating += head_word.rating_valid;
      end
    end
  end

  initial begin
    #LIMIT_NS;
    $display("accel_shock_impulse_detector_unit test failed");
    $finish;
  end

  initial begin
    stim_row_t          tab[$];
    logic signed [15:0] sx, sy, sz;
    int                 p;
    rst = 1'b1;
    in_valid = 1'b0;
    accel_x = '0;
    accel_y = '0;
    accel_z = '0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    cur_cfg = '{shock_threshold: asid_pkg::RST_SHOCK_THRESHOLD,
                window_length: asid_pkg::RST_WINDOW_LENGTH,
                report_period: asid_pkg::RST_REPORT_PERIOD,
                rating_scale: asid_pkg::RST_RATING_SCALE};
    last_smp = '{16'sd0, 16'sd0, 16'sd0};
    have_last = 1'b0;
    run_mean = '0;
    period_cnt = '0;
    win_open = 1'b0;
    win_cnt = '0;
    sum_x = 0;
    sum_y = 0;

    repeat (RST_CYCLES) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Directed table: rails, window edge cases, period and scale corners
    tab.push_back(sample_row(32767, -32768, 32767, 1, '0));          // first word: no diff
    tab.push_back(sample_row(-32768, 32767, -32768, 1, FULL_JUMP));  // full jump, opens
    tab.push_back(write_row(asid_pkg::REG_WINDOW_LENGTH, 2));
    tab.push_back(sample_row(-32768, 32767, -32768, 1, '0));
    tab.push_back(sample_row(32767, -32768, 32767, 1, FULL_JUMP));   // zero sums, reopens
    tab.push_back(sample_row(30000, -32768, 32767));
    tab.push_back(sample_row(30000, -32768, 32767, 1, '0));          // x negative
    tab.push_back(sample_row(30000, 32767, 32767));
    tab.push_back(sample_row(30000, 32000, 32767));
    tab.push_back(sample_row(30000, 32000, 32767, 1, '0));           // y negative
    tab.push_back(write_row(asid_pkg::REG_SHOCK_THRESHOLD, 0));
    tab.push_back(sample_row(0, 0, 0));
    tab.push_back(sample_row(100, -100, 0));
    tab.push_back(sample_row(100, -100, 0, 1, '0));                  // tie goes to x
    tab.push_back(write_row(asid_pkg::REG_WINDOW_LENGTH, 1));
    tab.push_back(sample_row(5, 5, 5));                              // short window
    tab.push_back(write_row(asid_pkg::REG_WINDOW_LENGTH, 1023));
    tab.push_back(write_row(asid_pkg::REG_SHOCK_THRESHOLD, 64'(ENERGY_MAX)));
    tab.push_back(sample_row(6, 5, 5, 1, 36'd1));
    tab.push_back(sample_row(6, 9, 5));
    tab.push_back(write_row(asid_pkg::REG_WINDOW_LENGTH, 2));        // lowered mid-window
    tab.push_back(sample_row(6, 9, 5, 1, '0));
    tab.push_back(write_row(asid_pkg::REG_REPORT_PERIOD, 0));
    tab.push_back(write_row(asid_pkg::REG_RATING_SCALE, 0));
    tab.push_back(sample_row(6, 9, 5, 1, '0));
    tab.push_back(sample_row(7, 9, 5, 1, 36'd1));
    tab.push_back(sample_row(7, 9, 5, 1, '0));
    tab.push_back(write_row(asid_pkg::REG_RATING_SCALE, 64'(ENERGY_MAX)));
    tab.push_back(write_row(asid_pkg::REG_REPORT_PERIOD, 1));
    tab.push_back(sample_row(8, 9, 5, 1, 36'd1));
    tab.push_back(sample_row(8, 9, 5, 1, '0));
    tab.push_back(write_row(asid_pkg::REG_RATING_SCALE, 1));
    tab.push_back(write_row(asid_pkg::REG_REPORT_PERIOD, 3));
    tab.push_back(sample_row(-32768, -32768, -32768));
    tab.push_back(sample_row(-32768, -32768, -32768, 1, '0));
    tab.push_back(sample_row(-32768, -32768, -32768, 1, '0));

    foreach (tab[i]) begin
      if (tab[i].kind == ROW_WRITE) begin
        wait_drained();
        reg_write(tab[i].reg_idx, tab[i].value);
      end else begin
        send_sample(tab[i].x, tab[i].y, tab[i].z, tab[i].energy_known, tab[i].energy);
      end
    end

    // Random phases, new settings each time
    for (p = 0; p < NUM_PHASES; p++) begin
      wait_drained();
      send_idle_pct = SEND_IDLE[p];
      stall_pct = RECV_STALL[p];
      reg_write(asid_pkg::REG_SHOCK_THRESHOLD, 64'($urandom_range(200, 1)) * 64'd1_000_000);
      reg_write(asid_pkg::REG_WINDOW_LENGTH, p == 2 ? 64'd1023 : 64'($urandom_range(12, 2)));
      reg_write(asid_pkg::REG_REPORT_PERIOD, p == 1 ? 64'hF_FFFF : 64'($urandom_range(25, 1)));
      reg_write(asid_pkg::REG_RATING_SCALE, p == 3 ? 64'd1 :
                64'($urandom_range(400_000_000, 10_000_000)));
      // long output hold while samples keep coming, to back the input up
      if (p == NUM_PHASES - 1) hold_req = 1'b1;
      repeat (PHASE_ITEMS) begin
        random_sample(sx, sy, sz);
        send_sample(sx, sy, sz, 1'b0, '0);
      end
    end

    wait_drained();
    repeat (TAIL_CYCLES) @(posedge clk);
    $display("Checked %0d of %0d words: %0d windows, %0d impact reports, %0d ratings.",
             n_checked, n_sent, n_trig, n_impact, n_rating);
    $display("Register corners plus %0d random phases with gaps, stalls and a long hold.",
             NUM_PHASES);
    if (errors == 0) begin
      $display("accel_shock_impulse_detector_unit test passed");
    end else begin
      $display("accel_shock_impulse_detector_unit test failed");
    end
    $finish;
  end

endmodule

FILE: filelist.f
rtl/core/asid_pkg.sv
rtl/core/asid_front.sv
rtl/core/asid_queue.sv
rtl/core/asid_div.sv
rtl/core/asid_back.sv
rtl/core/accel_shock_impulse_detector_unit.sv
tb/tb.sv
